[src/cht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, constants and helper functions of the callsign hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 256;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths
    localparam int OPCODE_W    = 2;
    localparam int WCODE_W     = 2;
    localparam int HASH_W      = 22;
    localparam int NAME_HIGH_W = 48;
    localparam int NAME_LOW_W  = 40;
    localparam int NAME_W      = NAME_HIGH_W + NAME_LOW_W;
    localparam int NAME_BYTES  = NAME_W / 8;
    localparam int STATUS_W    = 3;

    // Home slot: (10-bit slice * 23) mod TABLE_ENTRIES
    localparam int SLICE_W  = 10;
    localparam int HOME_MUL = 23;
    localparam int PROD_W   = $clog2(((1 << SLICE_W) - 1) * HOME_MUL + 1);
    // Reciprocal for the constant modulo; quotient estimate is off by at most one
    localparam int RECIP    = (1 << PROD_W) / TABLE_ENTRIES;
    localparam int RECIP_W  = $clog2(RECIP + 1);
    localparam int QP_W     = PROD_W + RECIP_W;

    // Lookup key shift per width code
    localparam int SH_KEY10 = 12;
    localparam int SH_KEY12 = 10;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [WCODE_W-1:0]  wcode_t;

    localparam addr_t LAST_SLOT = ADDR_W'(TABLE_ENTRIES - 1);

    // Opcodes
    localparam opcode_t OP_LOOKUP = 2'd0;
    localparam opcode_t OP_ADD    = 2'd1;
    localparam opcode_t OP_CLEAR  = 2'd2;

    // Lookup key width codes
    localparam wcode_t WC_KEY22 = 2'd0;
    localparam wcode_t WC_KEY12 = 2'd1;
    localparam wcode_t WC_KEY10 = 2'd2;

    // Result status codes
    localparam status_t ST_FOUND     = 3'd0;
    localparam status_t ST_NOT_FOUND = 3'd1;
    localparam status_t ST_INSERTED  = 3'd2;
    localparam status_t ST_PRESENT   = 3'd3;
    localparam status_t ST_FULL      = 3'd4;
    localparam status_t ST_CLEARED   = 3'd5;

    // One table entry as stored in memory
    typedef struct packed {
        logic [HASH_W-1:0]      hash;
        logic [NAME_HIGH_W-1:0] name_high;
        logic [NAME_LOW_W-1:0]  name_low;
    } entry_t;

    // Memory write and read requests
    typedef struct packed {
        logic   en;
        addr_t  addr;
        entry_t data;
    } ram_wr_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
    } ram_rd_t;

    // Home slot unit handshake
    typedef struct packed {
        logic               start;
        logic [SLICE_W-1:0] slice;
    } home_req_t;

    typedef struct packed {
        logic  done;
        addr_t slot;
    } home_rsp_t;

    // Zero every byte after the first zero byte of the name
    function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] name);
        logic [NAME_W-1:0] res;
        logic              ended;
        res   = name;
        ended = 1'b0;
        for (int b = 0; b < NAME_BYTES; b++) begin
            if (ended) begin
                res[NAME_W-1-8*b -: 8] = 8'h00;
            end
            else if (name[NAME_W-1-8*b -: 8] == 8'h00) begin
                ended = 1'b1;
            end
        end
        return res;
    endfunction

    // Linear probe step with wrap
    function automatic addr_t next_slot(input addr_t a);
        addr_t n;
        if (a == LAST_SLOT) begin
            n = '0;
        end
        else begin
            n = a + addr_t'(1);
        end
        return n;
    endfunction

endpackage : cht_pkg
`default_nettype wire

[src/cht_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_req_if / cht_rsp_if
// Valid/ready channels for table operations and their results.
// ----------------------------------------------------------------------------
interface cht_req_if import cht_pkg::*; ();
    logic                   valid;
    logic                   ready;
    opcode_t                opcode;
    wcode_t                 hash_width_code;
    logic [HASH_W-1:0]      key_hash;
    logic [NAME_HIGH_W-1:0] name_high;
    logic [NAME_LOW_W-1:0]  name_low;

    modport source (
        output valid, opcode, hash_width_code, key_hash, name_high, name_low,
        input  ready
    );
    modport sink (
        input  valid, opcode, hash_width_code, key_hash, name_high, name_low,
        output ready
    );
endinterface : cht_req_if

interface cht_rsp_if import cht_pkg::*; ();
    logic                   valid;
    logic                   ready;
    status_t                status;
    logic [NAME_HIGH_W-1:0] found_name_high;
    logic [NAME_LOW_W-1:0]  found_name_low;

    modport source (
        output valid, status, found_name_high, found_name_low,
        input  ready
    );
    modport sink (
        input  valid, status, found_name_high, found_name_low,
        output ready
    );
endinterface : cht_rsp_if
`default_nettype wire

[src/cht_entry_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_entry_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cht_entry_ram import cht_pkg::*; (
    input  wire logic    clk,
    input  wire ram_wr_t wr,
    input  wire ram_rd_t rd,
    output entry_t       rd_data
);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : cht_entry_ram
`default_nettype wire

[src/cht_home_calc.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cht_home_calc
// Home slot pipeline: slice * 23, reciprocal quotient estimate, then
// remainder with a single correction.
// ----------------------------------------------------------------------------
module cht_home_calc import cht_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire home_req_t req,
    output home_rsp_t      rsp
);

    logic                v0_reg, v1_reg, v2_reg;
    logic [PROD_W-1:0]   prod0_reg, prod0_next;
    logic [PROD_W-1:0]   prod1_reg;
    logic [QP_W-1:0]     qprod_reg, qprod_next;
    addr_t               slot_reg, slot_next;
    logic [RECIP_W-1:0]  quot;
    logic [PROD_W-1:0]   quot_n;
    logic [PROD_W-1:0]   rem;
    logic [PROD_W-1:0]   rem_fix;

    // Stage datapath
    always_comb
    begin
        prod0_next = PROD_W'(req.slice) * PROD_W'(HOME_MUL);
        qprod_next = QP_W'(prod0_reg) * QP_W'(RECIP);
        quot       = qprod_reg[QP_W-1:PROD_W];
        quot_n     = PROD_W'(quot * TABLE_ENTRIES);
        rem        = prod1_reg - quot_n;
        if (rem >= PROD_W'(TABLE_ENTRIES))
        begin
            rem_fix = rem - PROD_W'(TABLE_ENTRIES);
        end
        else
        begin
            rem_fix = rem;
        end
        slot_next = rem_fix[ADDR_W-1:0];
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= req.start;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Stage data
    always_ff @(posedge clk)
    begin
        prod0_reg <= prod0_next;
        prod1_reg <= prod0_reg;
        qprod_reg <= qprod_next;
        slot_reg  <= slot_next;
    end

    assign rsp.done = v2_reg;
    assign rsp.slot = slot_reg;

endmodule : cht_home_calc
`default_nettype wire

[src/callsign_hash_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// callsign_hash_table_core
// Open-addressing name table with linear probing, lookup, add and clear.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transaction (lookup, add, clear); rsp
//   returns exactly one result transaction for each, in order.
//   Lookup and add: the home slot unit computes the start slot, then one slot
//   is probed per cycle from the entry memory (one read port, registered
//   read data). A full sweep of the table bounds the probes at TABLE_ENTRIES.
//   An add to a table that is already full, and an unused opcode, answer
//   without probing. Clear writes zero to every entry, one per cycle.
//   One operation is in flight at a time; req.ready is high while the core
//   is idle, also while a finished result waits in the output register.
//   Reset: after rst_n releases, a clearing pass over all TABLE_ENTRIES
//   entries zeroes the memory; req.ready stays low until it is done.
//   If rsp stalls, the next result waits in the core until the output
//   register frees up.
// ----------------------------------------------------------------------------
module callsign_hash_table_core import cht_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    cht_req_if.sink   req,
    cht_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    opcode_t                op_reg, op_next;
    wcode_t                 code_reg, code_next;
    logic [HASH_W-1:0]      key_reg, key_next;
    logic [NAME_HIGH_W-1:0] name_high_reg, name_high_next;
    logic [NAME_LOW_W-1:0]  name_low_reg, name_low_next;
    addr_t                  cur_reg, cur_next;
    addr_t                  probe_reg, probe_next;
    addr_t                  sweep_reg, sweep_next;
    logic                   clr_op_reg, clr_op_next;
    count_t                 count_reg, count_next;
    status_t                res_status_reg, res_status_next;
    logic [NAME_HIGH_W-1:0] res_high_reg, res_high_next;
    logic [NAME_LOW_W-1:0]  res_low_reg, res_low_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    status_t                rsp_status_reg, rsp_status_next;
    logic [NAME_HIGH_W-1:0] rsp_high_reg, rsp_high_next;
    logic [NAME_LOW_W-1:0]  rsp_low_reg, rsp_low_next;

    ram_wr_t                mem_wr;
    ram_rd_t                mem_rd;
    entry_t                 mem_q;
    home_req_t              home_req;
    home_rsp_t              home_rsp;

    logic [NAME_W-1:0]      clean;
    logic                   slot_used;
    logic                   key_match;
    logic                   same_entry;
    logic                   last_probe;
    logic                   out_free;

    // Entry memory and home slot unit
    cht_entry_ram u_ram (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (mem_q)
    );

    cht_home_calc u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (home_req),
        .rsp   (home_rsp)
    );

    // Probe compare on the entry just read
    always_comb
    begin
        clean      = clean_name({req.name_high, req.name_low});
        slot_used  = (mem_q.name_high[NAME_HIGH_W-1 -: 8] != 8'h00);
        case (code_reg)
            WC_KEY10: key_match = ((mem_q.hash >> SH_KEY10) == key_reg);
            WC_KEY12: key_match = ((mem_q.hash >> SH_KEY12) == key_reg);
            default:  key_match = (mem_q.hash == key_reg);
        endcase
        same_entry = (mem_q.hash == key_reg) && (mem_q.name_high == name_high_reg)
                     && (mem_q.name_low == name_low_reg);
        last_probe = (probe_reg == LAST_SLOT);
        out_free   = !rsp_valid_reg || rsp.ready;
    end

    // Next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        code_next       = code_reg;
        key_next        = key_reg;
        name_high_next  = name_high_reg;
        name_low_next   = name_low_reg;
        cur_next        = cur_reg;
        probe_next      = probe_reg;
        sweep_next      = sweep_reg;
        clr_op_next     = clr_op_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_high_next   = res_high_reg;
        res_low_next    = res_low_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_high_next   = rsp_high_reg;
        rsp_low_next    = rsp_low_reg;
        mem_wr          = '0;
        mem_rd          = '0;
        home_req        = '0;

        // Output register drains on its transaction
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            // Zero the memory after reset or on clear
            S_SWEEP:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = sweep_reg;
                if (sweep_reg == LAST_SLOT)
                begin
                    count_next = '0;
                    if (clr_op_reg)
                    begin
                        res_status_next = ST_CLEARED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    sweep_next = sweep_reg + addr_t'(1);
                end
            end

            // Take a new operation
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next        = req.opcode;
                    code_next      = req.hash_width_code;
                    key_next       = req.key_hash;
                    name_high_next = clean[NAME_W-1 -: NAME_HIGH_W];
                    name_low_next  = clean[NAME_LOW_W-1:0];
                    res_high_next  = '0;
                    res_low_next   = '0;
                    case (req.opcode)
                        OP_LOOKUP:
                        begin
                            home_req.start = 1'b1;
                            case (req.hash_width_code)
                                WC_KEY10: home_req.slice = req.key_hash[9:0];
                                WC_KEY12: home_req.slice = req.key_hash[11:2];
                                default:  home_req.slice = req.key_hash[21:12];
                            endcase
                            state_next = S_HOME;
                        end
                        OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(TABLE_ENTRIES))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                home_req.start = 1'b1;
                                home_req.slice = req.key_hash[21:12];
                                state_next     = S_HOME;
                            end
                        end
                        OP_CLEAR:
                        begin
                            sweep_next  = '0;
                            clr_op_next = 1'b1;
                            state_next  = S_SWEEP;
                        end
                        default:
                        begin
                            res_status_next = ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            // Wait for the home slot, then read it
            S_HOME:
            begin
                if (home_rsp.done)
                begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = home_rsp.slot;
                    cur_next    = home_rsp.slot;
                    probe_next  = '0;
                    state_next  = S_PROBE;
                end
            end

            // One slot per cycle; the next slot is read ahead
            S_PROBE:
            begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = next_slot(cur_reg);
                if (op_reg == OP_LOOKUP)
                begin
                    if (!slot_used)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else if (key_match)
                    begin
                        res_status_next = ST_FOUND;
                        res_high_next   = mem_q.name_high;
                        res_low_next    = mem_q.name_low;
                        state_next      = S_DONE;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cur_next   = next_slot(cur_reg);
                        probe_next = probe_reg + addr_t'(1);
                    end
                end
                else
                begin
                    if (!slot_used)
                    begin
                        mem_wr.en             = 1'b1;
                        mem_wr.addr           = cur_reg;
                        mem_wr.data.hash      = key_reg;
                        mem_wr.data.name_high = name_high_reg;
                        mem_wr.data.name_low  = name_low_reg;
                        count_next            = count_reg + count_t'(1);
                        res_status_next       = ST_INSERTED;
                        state_next            = S_DONE;
                    end
                    else if (same_entry)
                    begin
                        res_status_next = ST_PRESENT;
                        state_next      = S_DONE;
                    end
                    else if (last_probe)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        cur_next   = next_slot(cur_reg);
                        probe_next = probe_reg + addr_t'(1);
                    end
                end
            end

            // Hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_high_next   = res_high_reg;
                    rsp_low_next    = res_low_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            op_reg         <= OP_LOOKUP;
            code_reg       <= WC_KEY22;
            key_reg        <= '0;
            name_high_reg  <= '0;
            name_low_reg   <= '0;
            cur_reg        <= '0;
            probe_reg      <= '0;
            sweep_reg      <= '0;
            clr_op_reg     <= 1'b0;
            count_reg      <= '0;
            res_status_reg <= ST_NOT_FOUND;
            res_high_reg   <= '0;
            res_low_reg    <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_NOT_FOUND;
            rsp_high_reg   <= '0;
            rsp_low_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            code_reg       <= code_next;
            key_reg        <= key_next;
            name_high_reg  <= name_high_next;
            name_low_reg   <= name_low_next;
            cur_reg        <= cur_next;
            probe_reg      <= probe_next;
            sweep_reg      <= sweep_next;
            clr_op_reg     <= clr_op_next;
            count_reg      <= count_next;
            res_status_reg <= res_status_next;
            res_high_reg   <= res_high_next;
            res_low_reg    <= res_low_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_high_reg   <= rsp_high_next;
            rsp_low_reg    <= rsp_low_next;
        end
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.found_name_high = rsp_high_reg;
    assign rsp.found_name_low  = rsp_low_reg;

`ifndef NO_ASSERTIONS
    // A found name comes from an occupied slot
    a_found_name_used: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status == ST_FOUND) |-> rsp.found_name_high[NAME_HIGH_W-1 -: 8] != 8'h00)
        else $error("found result carries an empty name");

    // Name fields are zero on every other status
    a_name_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_FOUND) |->
            (rsp.found_name_high == '0) && (rsp.found_name_low == '0))
        else $error("name fields not zero on a non-found result");

    // An insert bumps the fill count by one
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr.en && (state_reg == S_PROBE) |=> count_reg == $past(count_reg) + count_t'(1))
        else $error("fill count did not follow an insert");

    // One operation in flight: no back-to-back acceptance
    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("second operation accepted while one is in flight");
`endif

endmodule : callsign_hash_table_core
`default_nettype wire

[verif/callsign_hash_table_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// callsign_hash_table_core_tb
// Self-checking bench for the callsign hash table core. Lookup, add, clear
// and unused operations go in on the request channel. A behavioral copy of
// the table, kept in the bench, predicts every result not given by a directed
// row. Results are checked in order, field by field. A directed table covers
// the corner cases. After it come random traffic, a full fill of the table,
// and varying idle on both channels with one long stall of the result side.
// ----------------------------------------------------------------------------
module callsign_hash_table_core_tb;
    import cht_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_OPS     = 80;

    // Codes the package leaves unnamed
    localparam opcode_t OP_UNUSED = 2'd3;
    localparam wcode_t  WC_UNUSED = 2'd3;

    typedef struct {
        opcode_t                opcode;
        wcode_t                 code;
        logic [HASH_W-1:0]      key;
        logic [NAME_HIGH_W-1:0] name_high;
        logic [NAME_LOW_W-1:0]  name_low;
    } op_t;

    typedef struct {
        status_t                status;
        logic [NAME_HIGH_W-1:0] name_high;
        logic [NAME_LOW_W-1:0]  name_low;
    } result_t;

    typedef struct {
        op_t     item;
        bit      fixed;
        result_t want;
    } row_t;

    typedef struct {
        logic [HASH_W-1:0]      key;
        logic [NAME_HIGH_W-1:0] name_high;
        logic [NAME_LOW_W-1:0]  name_low;
    } name_rec_t;

    logic clk;
    logic rst_n;

    cht_req_if req_if ();
    cht_rsp_if rsp_if ();

    callsign_hash_table_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the table
    logic [NAME_HIGH_W-1:0] mirror_name_high [TABLE_ENTRIES];
    logic [NAME_LOW_W-1:0]  mirror_name_low  [TABLE_ENTRIES];
    logic [HASH_W-1:0]      mirror_hash      [TABLE_ENTRIES];
    int                     mirror_count;

    result_t   pending_results[$];
    row_t      directed_rows[$];
    name_rec_t added_names[$];

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_rsp = 1'b0;
    bit hold_served = 1'b0;
    int errors = 0;
    int quiet_cycles = 0;
    int op_seen[4];
    int status_seen[8];

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Table prediction
    // ------------------------------------------------------------------------
    function automatic int home_of(input logic [SLICE_W-1:0] slice);
        return (int'(slice) * HOME_MUL) % TABLE_ENTRIES;
    endfunction

    function automatic int lookup_shift(input wcode_t code);
        int sh;
        if (code == WC_KEY10)
        begin
            sh = 12;
        end
        else if (code == WC_KEY12)
        begin
            sh = 10;
        end
        else
        begin
            sh = 0;
        end
        return sh;
    endfunction

    // Zero every byte after the first NUL, walking from the first byte down
    function automatic logic [NAME_W-1:0] strip_after_nul(input logic [NAME_W-1:0] nm);
        logic [NAME_W-1:0] keep;
        bit                seen;
        keep = '1;
        seen = 1'b0;
        for (int b = NAME_BYTES - 1; b >= 0; b--)
        begin
            if (seen)
            begin
                keep[8*b +: 8] = 8'h00;
            end
            else if (nm[8*b +: 8] == 8'h00)
            begin
                seen = 1'b1;
            end
        end
        return nm & keep;
    endfunction

    function automatic bit slot_taken(input int idx);
        return mirror_name_high[idx][NAME_HIGH_W-1 -: 8] != 8'h00;
    endfunction

    function automatic void wipe_mirror();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            mirror_name_high[i] = '0;
            mirror_name_low[i]  = '0;
            mirror_hash[i]      = '0;
        end
        mirror_count = 0;
    endfunction

    // Result of one operation; updates the shadow table
    function automatic result_t predict_op(input op_t item);
        result_t           res;
        int                idx;
        int                sh;
        logic [NAME_W-1:0] nm;
        res = '{status: ST_NOT_FOUND, name_high: '0, name_low: '0};
        case (item.opcode)
            OP_LOOKUP:
            begin
                sh  = lookup_shift(item.code);
                idx = home_of(SLICE_W'(item.key >> (12 - sh)));
                for (int p = 0; p < TABLE_ENTRIES; p++)
                begin
                    if (!slot_taken(idx))
                    begin
                        break;
                    end
                    if ((mirror_hash[idx] >> sh) == item.key)
                    begin
                        res.status    = ST_FOUND;
                        res.name_high = mirror_name_high[idx];
                        res.name_low  = mirror_name_low[idx];
                        break;
                    end
                    idx = (idx + 1) % TABLE_ENTRIES;
                end
            end
            OP_ADD:
            begin
                nm         = strip_after_nul({item.name_high, item.name_low});
                res.status = ST_FULL;
                if (mirror_count < TABLE_ENTRIES)
                begin
                    idx = home_of(SLICE_W'(item.key >> 12));
                    for (int p = 0; p < TABLE_ENTRIES; p++)
                    begin
                        if (!slot_taken(idx))
                        begin
                            mirror_name_high[idx] = nm[NAME_W-1 -: NAME_HIGH_W];
                            mirror_name_low[idx]  = nm[NAME_LOW_W-1:0];
                            mirror_hash[idx]      = item.key;
                            mirror_count++;
                            res.status = ST_INSERTED;
                            break;
                        end
                        if (mirror_hash[idx] == item.key &&
                            {mirror_name_high[idx], mirror_name_low[idx]} == nm)
                        begin
                            res.status = ST_PRESENT;
                            break;
                        end
                        idx = (idx + 1) % TABLE_ENTRIES;
                    end
                end
            end
            OP_CLEAR:
            begin
                wipe_mirror();
                res.status = ST_CLEARED;
            end
            default:
            begin
                res.status = ST_NOT_FOUND;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Directed stimulus table
    // ------------------------------------------------------------------------
    function automatic void row_fixed(input opcode_t op, input wcode_t code,
                                      input logic [HASH_W-1:0] key,
                                      input logic [NAME_HIGH_W-1:0] nh,
                                      input logic [NAME_LOW_W-1:0] nl,
                                      input status_t st,
                                      input logic [NAME_HIGH_W-1:0] fh,
                                      input logic [NAME_LOW_W-1:0] fl);
        row_t r;
        r.item  = '{opcode: op, code: code, key: key, name_high: nh, name_low: nl};
        r.fixed = 1'b1;
        r.want  = '{status: st, name_high: fh, name_low: fl};
        directed_rows.push_back(r);
    endfunction

    function automatic void row_model(input opcode_t op, input wcode_t code,
                                      input logic [HASH_W-1:0] key,
                                      input logic [NAME_HIGH_W-1:0] nh,
                                      input logic [NAME_LOW_W-1:0] nl);
        row_t r;
        r.item  = '{opcode: op, code: code, key: key, name_high: nh, name_low: nl};
        r.fixed = 1'b0;
        r.want  = '{status: ST_NOT_FOUND, name_high: '0, name_low: '0};
        directed_rows.push_back(r);
    endfunction

    function automatic void build_directed_rows();
        // empty table after reset
        row_fixed(OP_LOOKUP, WC_KEY22, 22'h000000, 48'h0, 40'h0, ST_NOT_FOUND, 48'h0, 40'h0);
        row_fixed(OP_LOOKUP, WC_KEY22, 22'h3FFFFF, '1, '1, ST_NOT_FOUND, 48'h0, 40'h0);
        // all-ones hash and name, then the same add again
        row_fixed(OP_ADD, WC_KEY22, 22'h3FFFFF, '1, '1, ST_INSERTED, 48'h0, 40'h0);
        row_fixed(OP_ADD, WC_KEY22, 22'h3FFFFF, '1, '1, ST_PRESENT, 48'h0, 40'h0);
        // every key width finds it; width code 3 acts as 22 bits
        row_fixed(OP_LOOKUP, WC_KEY22, 22'h3FFFFF, 48'h0, 40'h0, ST_FOUND, '1, '1);
        row_fixed(OP_LOOKUP, WC_KEY12, 22'h000FFF, 48'h0, 40'h0, ST_FOUND, '1, '1);
        row_fixed(OP_LOOKUP, WC_KEY10, 22'h0003FF, 48'h0, 40'h0, ST_FOUND, '1, '1);
        row_fixed(OP_LOOKUP, WC_UNUSED, 22'h3FFFFF, 48'h0, 40'h0, ST_FOUND, '1, '1);
        // key wider than its width never matches
        row_fixed(OP_LOOKUP, WC_KEY10, 22'h0007FF, 48'h0, 40'h0, ST_NOT_FOUND, 48'h0, 40'h0);
        row_fixed(OP_LOOKUP, WC_KEY12, 22'h001FFF, 48'h0, 40'h0, ST_NOT_FOUND, 48'h0, 40'h0);
        // bytes after the terminator are dropped on add
        row_fixed(OP_ADD, WC_KEY22, 22'h000000, 48'h4142_0043_4445, 40'hFF_FFFF_FFFF,
                  ST_INSERTED, 48'h0, 40'h0);
        row_fixed(OP_LOOKUP, WC_KEY22, 22'h000000, 48'h0, 40'h0,
                  ST_FOUND, 48'h4142_0000_0000, 40'h0);
        // empty name takes a count but leaves its slot reading as empty
        row_model(OP_ADD, WC_KEY22, 22'h000123, 48'h0000_5A5A_5A5A, 40'h5A_5A5A_5A5A);
        row_model(OP_LOOKUP, WC_KEY22, 22'h000123, 48'h0, 40'h0);
        // same home slot, same hash with another name: probe moves on
        row_model(OP_ADD, WC_KEY22, 22'h000456, 48'h5831_4142_4300, 40'h0);
        row_model(OP_ADD, WC_KEY22, 22'h000456, 48'h5832_4142_4300, 40'h0);
        row_model(OP_LOOKUP, WC_KEY12, 22'h000001, 48'h0, 40'h0);
        // slice 0x059 homes to the last slot, so the second add wraps
        row_model(OP_ADD, WC_KEY22, 22'h059000, 48'h4E30_0000_0000, 40'h0);
        row_model(OP_ADD, WC_KEY22, 22'h059ABC, 48'h4E31_0000_0000, 40'h0);
        row_model(OP_LOOKUP, WC_KEY22, 22'h059ABC, 48'h0, 40'h0);
        // unused opcode changes nothing
        row_fixed(OP_UNUSED, WC_UNUSED, 22'h3FFFFF, '1, '1, ST_NOT_FOUND, 48'h0, 40'h0);
        // clear empties the table
        row_fixed(OP_CLEAR, WC_KEY22, 22'h000000, 48'h0, 40'h0, ST_CLEARED, 48'h0, 40'h0);
        row_fixed(OP_LOOKUP, WC_KEY22, 22'h3FFFFF, 48'h0, 40'h0, ST_NOT_FOUND, 48'h0, 40'h0);
        // smallest name that is not empty
        row_fixed(OP_ADD, WC_KEY22, 22'h000000, 48'h0100_0000_0000, 40'h0,
                  ST_INSERTED, 48'h0, 40'h0);
        row_fixed(OP_LOOKUP, WC_KEY10, 22'h000000, 48'h0, 40'h0,
                  ST_FOUND, 48'h0100_0000_0000, 40'h0);
    endfunction

    // ------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------
    // Hash slices; 0x000/0x100 and 0x059/0x159 share home slots, 0x059/0x159 the wrapping one
    function automatic logic [SLICE_W-1:0] crowded_slice();
        logic [SLICE_W-1:0] s;
        case ($urandom_range(0, 5))
            0:       s = 10'h000;
            1:       s = 10'h100;
            2:       s = 10'h059;
            3:       s = 10'h159;
            4:       s = 10'h3FF;
            default: s = 10'h0B3;
        endcase
        return s;
    endfunction

    function automatic logic [NAME_W-1:0] random_name();
        logic [NAME_W-1:0] nm;
        for (int b = 0; b < NAME_BYTES; b++)
        begin
            nm[8*b +: 8] = ($urandom_range(0, 11) == 0) ? 8'h00 : 8'($urandom);
        end
        return nm;
    endfunction

    function automatic op_t random_add(input bit keep_name);
        op_t               item;
        name_rec_t         rec;
        logic [NAME_W-1:0] nm;
        int                pick;
        nm             = random_name();
        item.opcode    = OP_ADD;
        item.code      = wcode_t'($urandom_range(0, 3));
        item.name_high = nm[NAME_W-1 -: NAME_HIGH_W];
        item.name_low  = nm[NAME_LOW_W-1:0];
        pick           = $urandom_range(0, 9);
        if (pick < 2 && added_names.size() > 0)
        begin
            // re-add a known hash, with its own name or a fresh one
            rec      = added_names[$urandom_range(0, added_names.size() - 1)];
            item.key = rec.key;
            if (pick == 0 || keep_name)
            begin
                item.name_high = rec.name_high;
                item.name_low  = rec.name_low;
            end
        end
        else if (pick < 7)
        begin
            item.key = {crowded_slice(), 12'($urandom)};
        end
        else
        begin
            item.key = HASH_W'($urandom);
        end
        added_names.push_back('{key: item.key, name_high: item.name_high,
                                name_low: item.name_low});
        return item;
    endfunction

    function automatic op_t random_lookup();
        op_t       item;
        name_rec_t rec;
        int        pick;
        item.opcode    = OP_LOOKUP;
        item.code      = wcode_t'($urandom_range(0, 3));
        item.name_high = NAME_HIGH_W'({$urandom, $urandom});
        item.name_low  = NAME_LOW_W'({$urandom, $urandom});
        pick           = $urandom_range(0, 9);
        if (pick < 6 && added_names.size() > 0)
        begin
            rec      = added_names[$urandom_range(0, added_names.size() - 1)];
            item.key = rec.key >> lookup_shift(item.code);
        end
        else if (pick < 7)
        begin
            // key with bits above its width
            if ($urandom_range(0, 1) == 0)
            begin
                item.code = WC_KEY10;
                item.key  = HASH_W'($urandom) | 22'h000400;
            end
            else
            begin
                item.code = WC_KEY12;
                item.key  = HASH_W'($urandom) | 22'h001000;
            end
        end
        else
        begin
            item.key = HASH_W'($urandom) >> lookup_shift(item.code);
        end
        return item;
    endfunction

    function automatic op_t random_op();
        op_t item;
        int  r;
        r = $urandom_range(0, 99);
        if (r < 46)
        begin
            item = random_add(1'b0);
        end
        else if (r < 90)
        begin
            item = random_lookup();
        end
        else
        begin
            item.opcode    = (r < 94) ? OP_CLEAR : OP_UNUSED;
            item.code      = wcode_t'($urandom_range(0, 3));
            item.key       = HASH_W'($urandom);
            item.name_high = NAME_HIGH_W'({$urandom, $urandom});
            item.name_low  = NAME_LOW_W'({$urandom, $urandom});
        end
        return item;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    task automatic apply_op(input op_t item, input bit fixed, input result_t want);
        result_t model_res;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid           <= 1'b1;
        req_if.opcode          <= item.opcode;
        req_if.hash_width_code <= item.code;
        req_if.key_hash        <= item.key;
        req_if.name_high       <= item.name_high;
        req_if.name_low        <= item.name_low;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
        // transaction accepted: predict in acceptance order
        model_res = predict_op(item);
        pending_results.push_back(fixed ? want : model_res);
        op_seen[item.opcode]++;
    endtask

    task automatic apply_random(input op_t item);
        result_t none;
        none = '{status: ST_NOT_FOUND, name_high: '0, name_low: '0};
        apply_op(item, 1'b0, none);
    endtask

    // Stop sending until every result is back
    task automatic wait_results();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side ready, with random idle and a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_rsp && !hold_served)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_served = 1'b1;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            quiet_cycles <= 0;
            if (pending_results.size() == 0)
            begin
                $error("result with none pending: status %0d", rsp_if.status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (rsp_if.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    errors++;
                end
                if (rsp_if.found_name_high !== want.name_high)
                begin
                    $error("found_name_high: expected %h, got %h",
                           want.name_high, rsp_if.found_name_high);
                    errors++;
                end
                if (rsp_if.found_name_low !== want.name_low)
                begin
                    $error("found_name_low: expected %h, got %h",
                           want.name_low, rsp_if.found_name_low);
                    errors++;
                end
            end
        end
        else if (req_if.valid && req_if.ready)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     quiet_cycles, pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        op_t item;
        rst_n                  <= 1'b0;
        req_if.valid           <= 1'b0;
        req_if.opcode          <= OP_LOOKUP;
        req_if.hash_width_code <= WC_KEY22;
        req_if.key_hash        <= '0;
        req_if.name_high       <= '0;
        req_if.name_low        <= '0;
        send_idle_pct = 36;
        recv_idle_pct = 74;
        wipe_mirror();
        build_directed_rows();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed corner cases
        foreach (directed_rows[i])
        begin
            apply_op(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
        end

        // random mix, sender idles less than receiver
        repeat (RANDOM_OPS) apply_random(random_op());
        wait_results();

        // random mix, roles swapped
        send_idle_pct = 74;
        recv_idle_pct = 36;
        repeat (RANDOM_OPS) apply_random(random_op());
        wait_results();

        // no idle: fill the table to full while the result side stalls
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_rsp      = 1'b1;
        item = '{opcode: OP_CLEAR, code: WC_KEY22, key: '0, name_high: '0, name_low: '0};
        apply_random(item);
        while (mirror_count < TABLE_ENTRIES)
        begin
            item = random_add(1'b1);
            if (item.name_high[NAME_HIGH_W-1 -: 8] == 8'h00)
            begin
                item.name_high[NAME_HIGH_W-1 -: 8] = 8'($urandom_range(1, 255));
            end
            apply_random(item);
        end
        // full table: adds are refused, misses sweep every slot
        repeat (8) apply_random(random_add(1'b0));
        repeat (24) apply_random(random_lookup());
        wait_results();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d lookups, %0d adds, %0d clears, %0d unused operations",
                 op_seen[OP_LOOKUP], op_seen[OP_ADD], op_seen[OP_CLEAR], op_seen[OP_UNUSED]);
        $display("results: found %0d, missed %0d, inserted %0d, present %0d, full %0d, %s %0d",
                 status_seen[ST_FOUND], status_seen[ST_NOT_FOUND], status_seen[ST_INSERTED],
                 status_seen[ST_PRESENT], status_seen[ST_FULL], "cleared",
                 status_seen[ST_CLEARED]);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule : callsign_hash_table_core_tb

[callsign_hash_table_core.f]
src/cht_pkg.sv
src/cht_if.sv
src/cht_entry_ram.sv
src/cht_home_calc.sv
src/callsign_hash_table_core.sv
verif/callsign_hash_table_core_tb.sv
